// ===== design/life_automaton_grid_engine_assert.svh =====
// Assertion macros for the life grid engine.
// Expects clk and rst in the scope of each use.
`ifndef LIFE_AUTOMATON_GRID_ENGINE_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_ENGINE_ASSERT_SVH

// same-cycle implication
`define LAGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lage_pkg.sv =====
// Shared types and constants of the life grid engine.
// No dependencies; used by every other file but the assertion header.
package lage_pkg;

  localparam int GRID_SIZE     = 64;
  localparam int ADDR_W        = $clog2(GRID_SIZE);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int FIELD_W       = 6;
  localparam int ACTION_W      = 2;
  localparam int NBR_W         = 4;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  typedef logic [GRID_SIZE-1:0] row_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STEP  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_FLUSH,
    S_EDIT
  } state_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    row_t  data;
  } mem_wr_t;

endpackage

// ===== design/lage_if.sv =====
// Handshake channels of the life grid engine: command, response, config.
// Depends on lage_pkg for field widths.
interface lage_in_if;
  logic                         valid;
  logic                         ready;
  logic [lage_pkg::ACTION_W-1:0] action;
  logic [lage_pkg::FIELD_W-1:0]  col;
  logic [lage_pkg::FIELD_W-1:0]  row;
  modport source (output valid, action, col, row, input ready);
  modport sink   (input valid, action, col, row, output ready);
endinterface

interface lage_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic changed;
  logic status;
  modport source (output valid, cell_alive, changed, status, input ready);
  modport sink   (input valid, cell_alive, changed, status, output ready);
endinterface

interface lage_cfg_if;
  logic valid;
  logic ready;
  logic run_enable;
  modport source (output valid, run_enable, input ready);
  modport sink   (input valid, run_enable, output ready);
endinterface

// ===== design/lage_row_mem.sv =====
// One generation buffer: GRID_SIZE rows of GRID_SIZE cells.
// One write port, one read port with registered data. Depends on lage_pkg.
module lage_row_mem (
  input  logic              clk,
  input  lage_pkg::mem_wr_t wr,
  input  lage_pkg::addr_t   raddr,
  output lage_pkg::row_t    rdata
);

  lage_pkg::row_t mem [lage_pkg::GRID_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lage_row_rule.sv =====
// B3/S23 update of one row from its three-row window, dead border.
// Depends on lage_pkg.
module lage_row_rule (
  input  lage_pkg::row_t above,
  input  lage_pkg::row_t mid,
  input  lage_pkg::row_t below,
  output lage_pkg::row_t next_row,
  output logic           diff
);

  always_comb begin
    logic [7:0]                 nb;
    logic [lage_pkg::NBR_W-1:0] n;
    for (int c = 0; c < lage_pkg::GRID_SIZE; c++) begin
      nb    = '0;
      nb[0] = above[c];
      nb[1] = below[c];
      if (c > 0) begin
        nb[2] = above[c-1];
        nb[3] = mid[c-1];
        nb[4] = below[c-1];
      end
      if (c < lage_pkg::GRID_SIZE - 1) begin
        nb[5] = above[c+1];
        nb[6] = mid[c+1];
        nb[7] = below[c+1];
      end
      n = lage_pkg::NBR_W'($countones(nb));
      next_row[c] = (n == lage_pkg::NBR_W'(lage_pkg::BIRTH_COUNT)) ||
                    (mid[c] && (n == lage_pkg::NBR_W'(lage_pkg::SURVIVE_COUNT)));
    end
    diff = |(next_row ^ mid);
  end

endmodule

// ===== design/life_automaton_grid_engine.sv =====
// Life grid engine. Step with run_enable set: a sweep through the buffer read port,
// one row per cycle, then a window flush, before the response.
// Set and clear: row read, modify, write back; read: row read only. Frozen step and
// out-of-range address are answered from dispatch. One item in flight; cmd.ready high
// only when idle. Reset (rst, synchronous): a clearing pass over all GRID_SIZE rows zeroes
// both buffers, cmd.ready stays low during it; config writes are taken outside reset.
module life_automaton_grid_engine (
  input  logic        clk,
  input  logic        rst,
  lage_in_if.sink     cmd,
  lage_out_if.source  rsp,
  lage_cfg_if.sink    cfg
);

  lage_pkg::state_t  state, state_next;
  lage_pkg::mem_wr_t wr [2];
  lage_pkg::addr_t   raddr;
  lage_pkg::row_t    rdata [2];
  lage_pkg::row_t    rdata_cur;
  lage_pkg::row_t    rule_below;
  lage_pkg::row_t    rule_next;
  lage_pkg::row_t    edit_word;
  logic              rule_diff;

  lage_pkg::addr_t   clr_row;
  logic              cur_buf;
  logic              pending;
  logic              run_en;
  logic              rsp_valid;
  logic              rsp_alive;
  logic              rsp_changed;
  logic              rsp_status;

  lage_pkg::action_t item_act;
  lage_pkg::addr_t   item_row;
  lage_pkg::addr_t   item_col;
  logic              item_oor;
  lage_pkg::row_t    prev;
  lage_pkg::row_t    mid;
  logic              any;
  logic              first;
  logic [lage_pkg::CNT_W-1:0] issue_cnt;
  lage_pkg::addr_t   wr_row;

  logic              out_free;
  logic              load_out;
  logic              res_alive;
  logic              res_changed;
  logic              res_status;

  lage_row_mem u_mem0 (.clk(clk), .wr(wr[0]), .raddr(raddr), .rdata(rdata[0]));
  lage_row_mem u_mem1 (.clk(clk), .wr(wr[1]), .raddr(raddr), .rdata(rdata[1]));

  lage_row_rule u_rule (
    .above(prev), .mid(mid), .below(rule_below), .next_row(rule_next), .diff(rule_diff)
  );

  assign rdata_cur      = cur_buf ? rdata[1] : rdata[0];
  assign out_free       = !rsp_valid || rsp.ready;
  assign rsp.valid      = rsp_valid;
  assign rsp.cell_alive = rsp_alive;
  assign rsp.changed    = rsp_changed;
  assign rsp.status     = rsp_status;
  assign cfg.ready      = 1'b1;

  always_comb begin
    edit_word = rdata_cur;
    if (item_act == lage_pkg::ACT_SET) begin
      edit_word[item_col] = 1'b1;
    end else if (item_act == lage_pkg::ACT_CLEAR) begin
      edit_word[item_col] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lage_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.ready   = 1'b0;
    raddr       = item_row;
    wr[0]       = '0;
    wr[1]       = '0;
    rule_below  = rdata_cur;
    load_out    = 1'b0;
    res_alive   = 1'b0;
    res_changed = pending;
    res_status  = 1'b0;
    case (state)
      lage_pkg::S_CLEAR: begin
        wr[0].en   = 1'b1;
        wr[0].addr = clr_row;
        wr[1].en   = 1'b1;
        wr[1].addr = clr_row;
        if (clr_row == lage_pkg::addr_t'(lage_pkg::GRID_SIZE - 1)) begin
          state_next = lage_pkg::S_IDLE;
        end
      end
      lage_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = lage_pkg::S_DISPATCH;
        end
      end
      lage_pkg::S_DISPATCH: begin
        if (item_act == lage_pkg::ACT_STEP) begin
          if (run_en) begin
            raddr      = '0;
            state_next = lage_pkg::S_SWEEP;
          end else if (out_free) begin
            load_out   = 1'b1;
            state_next = lage_pkg::S_IDLE;
          end
        end else if (item_oor) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_status = 1'b1;
            state_next = lage_pkg::S_IDLE;
          end
        end else begin
          state_next = lage_pkg::S_EDIT;
        end
      end
      lage_pkg::S_SWEEP: begin
        raddr             = issue_cnt[lage_pkg::ADDR_W-1:0];
        wr[!cur_buf].en   = !first;
        wr[!cur_buf].addr = wr_row;
        wr[!cur_buf].data = rule_next;
        if (issue_cnt == lage_pkg::CNT_W'(lage_pkg::GRID_SIZE)) begin
          state_next = lage_pkg::S_FLUSH;
        end
      end
      lage_pkg::S_FLUSH: begin
        rule_below = '0;
        if (out_free) begin
          wr[!cur_buf].en   = 1'b1;
          wr[!cur_buf].addr = wr_row;
          wr[!cur_buf].data = rule_next;
          load_out          = 1'b1;
          res_changed       = pending || any || rule_diff;
          state_next        = lage_pkg::S_IDLE;
        end
      end
      lage_pkg::S_EDIT: begin
        if (out_free) begin
          if (item_act != lage_pkg::ACT_READ) begin
            wr[cur_buf].en   = 1'b1;
            wr[cur_buf].addr = item_row;
            wr[cur_buf].data = edit_word;
            res_changed      = 1'b1;
          end
          res_alive  = edit_word[item_col];
          load_out   = 1'b1;
          state_next = lage_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lage_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      cur_buf   <= 1'b0;
      pending   <= 1'b1;
      run_en    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        run_en <= cfg.run_enable;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        lage_pkg::S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
        end
        lage_pkg::S_DISPATCH: begin
          if (item_act == lage_pkg::ACT_STEP && !run_en && out_free) begin
            pending <= 1'b0;
          end
        end
        lage_pkg::S_FLUSH: begin
          if (out_free) begin
            cur_buf <= !cur_buf;
            pending <= 1'b0;
          end
        end
        lage_pkg::S_EDIT: begin
          if (out_free && item_act != lage_pkg::ACT_READ) begin
            pending <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_alive   <= res_alive;
      rsp_changed <= res_changed;
      rsp_status  <= res_status;
    end
    case (state)
      lage_pkg::S_IDLE: begin
        item_act <= lage_pkg::action_t'(cmd.action);
        item_row <= lage_pkg::ADDR_W'(cmd.row);
        item_col <= lage_pkg::ADDR_W'(cmd.col);
        item_oor <= (int'(cmd.col) >= lage_pkg::GRID_SIZE) ||
                    (int'(cmd.row) >= lage_pkg::GRID_SIZE);
      end
      lage_pkg::S_DISPATCH: begin
        issue_cnt <= lage_pkg::CNT_W'(1);
        first     <= 1'b1;
        wr_row    <= '0;
        prev      <= '0;
        mid       <= '0;
        any       <= 1'b0;
      end
      lage_pkg::S_SWEEP: begin
        prev      <= mid;
        mid       <= rdata_cur;
        first     <= 1'b0;
        issue_cnt <= issue_cnt + 1'b1;
        if (!first) begin
          wr_row <= wr_row + 1'b1;
          any    <= any || rule_diff;
        end
      end
      default: begin
      end
    endcase
  end

`include "life_automaton_grid_engine_assert.svh"

  `LAGE_ASSERT_NOW(a_load_free, load_out, !rsp.valid || rsp.ready, "response overwritten")
  `LAGE_ASSERT_NEXT(a_one_in_flight, cmd.valid && cmd.ready, !cmd.ready, "second beat taken")
  `LAGE_ASSERT_NEXT(a_buf_swap, !(state == lage_pkg::S_FLUSH && out_free), $stable(cur_buf), "buffer swapped outside flush")
  `LAGE_ASSERT_NOW(a_sweep_target, state == lage_pkg::S_SWEEP || state == lage_pkg::S_FLUSH, !wr[cur_buf].en, "sweep wrote current buffer")

endmodule
